>>> rtl/core/iptp_pkg.sv
// Shared types and constants for the address text parser.
// Character classes, the queued request format and the end-of-text snapshot.
// No dependencies.
package iptp_pkg;

	// class of one text character as seen by the parser
	typedef enum logic [2:0] {
		KIND_DEC,
		KIND_HEX,
		KIND_DOT,
		KIND_COLON,
		KIND_LBR,
		KIND_RBR,
		KIND_OTHER
	} kind_t;

	// one classified character waiting in the queue
	typedef struct packed {
		kind_t      kind;
		logic [3:0] nib;
		logic       last;
	} token_t;

	// parse state reduced at the end of the text
	typedef struct packed {
		logic             dotted_only;
		logic             v4_ok;
		logic             v6_ok;
		logic             full_form;
		logic [2:0]       colons;
		logic [2:0]       dc_pos;
		logic [3:0][7:0]  quad;
		logic [7:0][15:0] group;
	} snap_t;

	localparam logic [63:0] V4_MAPPED_PREFIX = 64'h0000_FFFF_0000_0000;
	localparam logic [15:0] GROUP_MAX        = 16'hFFFF;
	localparam logic [7:0]  QUAD_MAX         = 8'd255;
	localparam logic [2:0]  DOTS_MAX         = 3'd4;
	localparam logic [3:0]  COLONS_MAX       = 4'd8;
	localparam logic [3:0]  COLONS_FULL      = 4'd7;
	localparam logic [2:0]  DOTS_V4          = 3'd3;

endpackage

>>> rtl/core/iptp_front.sv
// Front end of the address text parser: classifies each incoming character.
// Uses iptp_pkg for the token format.
module iptp_front (
	input  logic              text_valid,
	output logic              text_ready,
	input  logic [7:0]        character,
	input  logic              last,
	output logic              push,
	output iptp_pkg::token_t  push_tok,
	input  logic              push_ready
);

	assign text_ready = push_ready;
	assign push       = text_valid && push_ready;

	always_comb begin
		push_tok.last = last;
		push_tok.nib  = character[3:0];
		if (character >= 8'h30 && character <= 8'h39) begin
			push_tok.kind = iptp_pkg::KIND_DEC;
		end else if ((character >= 8'h41 && character <= 8'h46) ||
				(character >= 8'h61 && character <= 8'h66)) begin
			// letters A-F and a-f: low nibble 1..6 maps to 10..15
			push_tok.kind = iptp_pkg::KIND_HEX;
			push_tok.nib  = character[3:0] + 4'd9;
		end else if (character == 8'h2E) begin
			push_tok.kind = iptp_pkg::KIND_DOT;
		end else if (character == 8'h3A) begin
			push_tok.kind = iptp_pkg::KIND_COLON;
		end else if (character == 8'h5B) begin
			push_tok.kind = iptp_pkg::KIND_LBR;
		end else if (character == 8'h5D) begin
			push_tok.kind = iptp_pkg::KIND_RBR;
		end else begin
			push_tok.kind = iptp_pkg::KIND_OTHER;
		end
	end

endmodule

>>> rtl/core/iptp_queue.sv
// Short request queue between the classifier and the parse engine.
// Uses iptp_pkg for the token format.
module iptp_queue #(
	parameter int Depth = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  iptp_pkg::token_t  push_tok,
	output logic              push_ready,
	output logic              pop_valid,
	output iptp_pkg::token_t  pop_tok,
	input  logic              pop
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	iptp_pkg::token_t mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - CntW'(1))
		else $error("queue count lost a request");

endmodule

>>> rtl/core/iptp_back.sv
// Parse engine: runs the IPv4 and IPv6 parse state on each queued character
// and hands a reduced snapshot on at the end of the text. Uses iptp_pkg.
module iptp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	input  iptp_pkg::token_t  tok,
	output logic              tok_ready,
	output logic              snap_valid,
	output iptp_pkg::snap_t   snap,
	input  logic              snap_ready
);

	logic [7:0][15:0] grp_val_q, grp_val_d;
	logic [7:0]       grp_ovf_q, grp_ovf_d;
	logic [3:0]       colons_q, colons_d;
	logic             dc_seen_q, dc_seen_d;
	logic [2:0]       dc_pos_q, dc_pos_d;
	logic             prev_colon_q, prev_colon_d;
	logic             br_open_q, br_open_d;
	logic             br_closed_q, br_closed_d;
	logic             err_q, err_d;
	logic             dotted_q, dotted_d;
	logic [2:0]       dots_q, dots_d;
	logic [3:0][7:0]  quad_q, quad_d;
	logic [3:0]       quad_ovf_q, quad_ovf_d;
	logic [3:0]       quad_dig_q, quad_dig_d;
	logic             first_q;
	logic             pop;
	logic             is_digit;
	logic [11:0]      quad_sum;
	logic [15:0]      grp_cur;
	logic [7:0]       quad_cur;

	assign tok_ready  = !tok.last || snap_ready;
	assign pop        = tok_valid && tok_ready;
	assign snap_valid = tok_valid && tok.last;
	assign is_digit   = (tok.kind == iptp_pkg::KIND_DEC) || (tok.kind == iptp_pkg::KIND_HEX);
	assign quad_cur   = quad_q[dots_q[1:0]];
	assign grp_cur    = grp_val_q[colons_q[2:0]];
	// value * 10 + digit
	assign quad_sum   = {1'b0, quad_cur, 3'b000} + {3'b000, quad_cur, 1'b0} + {8'h00, tok.nib};

	always_comb begin
		grp_val_d    = grp_val_q;
		grp_ovf_d    = grp_ovf_q;
		colons_d     = colons_q;
		dc_seen_d    = dc_seen_q;
		dc_pos_d     = dc_pos_q;
		br_open_d    = br_open_q;
		br_closed_d  = br_closed_q;
		err_d        = err_q;
		dotted_d     = dotted_q;
		dots_d       = dots_q;
		quad_d       = quad_q;
		quad_ovf_d   = quad_ovf_q;
		quad_dig_d   = quad_dig_q;
		prev_colon_d = (tok.kind == iptp_pkg::KIND_COLON);

		// dotted-quad view
		if (tok.kind == iptp_pkg::KIND_DEC) begin
			if (dots_q < iptp_pkg::DOTS_MAX) begin
				if (quad_sum > {4'h0, iptp_pkg::QUAD_MAX}) begin
					quad_ovf_d[dots_q[1:0]] = 1'b1;
					quad_d[dots_q[1:0]]     = iptp_pkg::QUAD_MAX;
				end else begin
					quad_d[dots_q[1:0]]     = quad_sum[7:0];
				end
				quad_dig_d[dots_q[1:0]] = 1'b1;
			end
		end else if (tok.kind == iptp_pkg::KIND_DOT) begin
			if (dots_q < iptp_pkg::DOTS_MAX) begin
				dots_d = dots_q + 3'd1;
			end
		end else begin
			dotted_d = 1'b0;
		end

		// colon-hex view
		if (br_closed_q) begin
			err_d = 1'b1;
		end else if (tok.kind == iptp_pkg::KIND_LBR) begin
			if (first_q) br_open_d = 1'b1;
			else         err_d     = 1'b1;
		end else if (tok.kind == iptp_pkg::KIND_RBR) begin
			if (br_open_q) br_closed_d = 1'b1;
			else           err_d       = 1'b1;
		end else if (tok.kind == iptp_pkg::KIND_COLON) begin
			if (prev_colon_q) begin
				if (dc_seen_q) begin
					err_d = 1'b1;
				end else begin
					dc_seen_d = 1'b1;
					dc_pos_d  = colons_q[2:0] - 3'd1;
				end
			end
			if (colons_q < iptp_pkg::COLONS_MAX) begin
				colons_d = colons_q + 4'd1;
			end
		end else if (is_digit) begin
			if (colons_q < iptp_pkg::COLONS_MAX) begin
				if (grp_cur[15:12] != 4'h0) begin
					grp_ovf_d[colons_q[2:0]] = 1'b1;
					grp_val_d[colons_q[2:0]] = iptp_pkg::GROUP_MAX;
				end else begin
					grp_val_d[colons_q[2:0]] = {grp_cur[11:0], tok.nib};
				end
			end
		end else begin
			err_d = 1'b1;
		end
	end

	always_comb begin
		snap.dotted_only = dotted_d;
		snap.v4_ok       = (dots_d == iptp_pkg::DOTS_V4) && (quad_ovf_d == 4'h0) &&
			(quad_dig_d == 4'hF);
		snap.v6_ok       = !err_d && (colons_d < iptp_pkg::COLONS_MAX) &&
			(br_open_d == br_closed_d) &&
			((colons_d == iptp_pkg::COLONS_FULL) || dc_seen_d) && (grp_ovf_d == 8'h00);
		snap.full_form   = (colons_d == iptp_pkg::COLONS_FULL);
		snap.colons      = colons_d[2:0];
		snap.dc_pos      = dc_pos_d;
		snap.quad        = quad_d;
		snap.group       = grp_val_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_val_q    <= '0;
			grp_ovf_q    <= '0;
			colons_q     <= '0;
			dc_seen_q    <= 1'b0;
			dc_pos_q     <= '0;
			prev_colon_q <= 1'b0;
			br_open_q    <= 1'b0;
			br_closed_q  <= 1'b0;
			err_q        <= 1'b0;
			dotted_q     <= 1'b1;
			dots_q       <= '0;
			quad_q       <= '0;
			quad_ovf_q   <= '0;
			quad_dig_q   <= '0;
			first_q      <= 1'b1;
		end else if (pop) begin
			if (tok.last) begin
				// end of text: start the next string from scratch
				grp_val_q    <= '0;
				grp_ovf_q    <= '0;
				colons_q     <= '0;
				dc_seen_q    <= 1'b0;
				dc_pos_q     <= '0;
				prev_colon_q <= 1'b0;
				br_open_q    <= 1'b0;
				br_closed_q  <= 1'b0;
				err_q        <= 1'b0;
				dotted_q     <= 1'b1;
				dots_q       <= '0;
				quad_q       <= '0;
				quad_ovf_q   <= '0;
				quad_dig_q   <= '0;
				first_q      <= 1'b1;
			end else begin
				grp_val_q    <= grp_val_d;
				grp_ovf_q    <= grp_ovf_d;
				colons_q     <= colons_d;
				dc_seen_q    <= dc_seen_d;
				dc_pos_q     <= dc_pos_d;
				prev_colon_q <= prev_colon_d;
				br_open_q    <= br_open_d;
				br_closed_q  <= br_closed_d;
				err_q        <= err_d;
				dotted_q     <= dotted_d;
				dots_q       <= dots_d;
				quad_q       <= quad_d;
				quad_ovf_q   <= quad_ovf_d;
				quad_dig_q   <= quad_dig_d;
				first_q      <= 1'b0;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop && tok.last |=> first_q && dotted_q && (colons_q == 4'd0) && (dots_q == 3'd0))
		else $error("parse state not cleared after end of text");

endmodule

>>> rtl/core/iptp_finish.sv
// Result stage: expands '::' into zero groups, forms the 128-bit address and
// holds the result until taken. Uses iptp_pkg.
module iptp_finish (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             snap_valid,
	input  iptp_pkg::snap_t  snap,
	output logic             snap_ready,
	output logic             result_valid,
	input  logic             result_ready,
	output logic             addr_valid,
	output logic             mapped_v4,
	output logic [63:0]      addr_high,
	output logic [63:0]      addr_low
);

	logic             fin_valid_s2;
	iptp_pkg::snap_t  snap_s2;
	logic             out_valid_q;
	logic             res_valid_q;
	logic             res_v4_q;
	logic [63:0]      res_high_q;
	logic [63:0]      res_low_q;
	logic             out_free;
	logic             fin_move;
	logic [7:0][15:0] grp;
	logic             ok;
	logic             v4;
	logic [63:0]      high;
	logic [63:0]      low;

	assign out_free   = !out_valid_q || result_ready;
	assign fin_move   = fin_valid_s2 && out_free;
	assign snap_ready = !fin_valid_s2 || out_free;

	// place groups after the '::' gap at the tail of the address
	always_comb begin
		logic [4:0] gap_end;
		logic [2:0] src;
		gap_end = {2'b00, snap_s2.dc_pos} + 5'd8 - {2'b00, snap_s2.colons};
		for (int i = 0; i < 8; i++) begin
			src = 3'(i) + snap_s2.colons + 3'd1;
			if (snap_s2.full_form || (5'(i) <= {2'b00, snap_s2.dc_pos})) begin
				grp[i] = snap_s2.group[i];
			end else if (5'(i) <= gap_end) begin
				grp[i] = '0;
			end else begin
				grp[i] = snap_s2.group[src];
			end
		end
	end

	always_comb begin
		high = '0;
		low  = '0;
		v4   = 1'b0;
		if (snap_s2.dotted_only) begin
			ok = snap_s2.v4_ok;
			v4 = snap_s2.v4_ok;
			if (snap_s2.v4_ok) begin
				low = iptp_pkg::V4_MAPPED_PREFIX |
					{32'h0, snap_s2.quad[0], snap_s2.quad[1], snap_s2.quad[2], snap_s2.quad[3]};
			end
		end else begin
			ok = snap_s2.v6_ok;
			if (snap_s2.v6_ok) begin
				high = {grp[0], grp[1], grp[2], grp[3]};
				low  = {grp[4], grp[5], grp[6], grp[7]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			snap_s2 <= snap;
		end
		if (fin_move) begin
			res_valid_q <= ok;
			res_v4_q    <= v4;
			res_high_q  <= high;
			res_low_q   <= low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (snap_ready) begin
				fin_valid_s2 <= snap_valid;
			end
			if (out_free) begin
				out_valid_q <= fin_move;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign addr_valid   = res_valid_q;
	assign mapped_v4    = res_v4_q;
	assign addr_high    = res_high_q;
	assign addr_low     = res_low_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !addr_valid |-> !mapped_v4 && (addr_high == '0) && (addr_low == '0))
		else $error("invalid result carries an address");

	a_snap_held: assert property (@(posedge clk) disable iff (!arst_n)
		fin_valid_s2 && !out_free |=> fin_valid_s2 && $stable(snap_s2))
		else $error("pending snapshot lost while output stalled");

endmodule

>>> rtl/core/ip_address_text_parser_unit.sv
// IP address text parser: address text in, 128-bit binary address out.
// Ties together classifier, request queue, parse engine and result stage.
// Depends on iptp_pkg, iptp_front, iptp_queue, iptp_back, iptp_finish.
//
// Usage:
//  - The text channel (text_valid/text_ready, character, last) takes one
//    character per request; last marks the final character of a string.
//  - The result channel (result_valid/result_ready) gives one result per
//    string: addr_valid, mapped_v4 and the address in addr_high/addr_low.
//    Dotted-quad text comes back as ::ffff:a.b.c.d with mapped_v4 set;
//    invalid text gives zero address and addr_valid low.
//  - One character is taken every cycle while the queue has room; the parse
//    engine updates its state once per character.
//  - Result path: the last character passes the queue entry, the snapshot
//    register and the result register before result_valid rises.
//  - A stalled receiver holds the result register; the snapshot stage and
//    the queue keep taking requests until they fill, then text_ready drops.
//  - Reset clears the queue, the parse state and the valid flags of both
//    result stages; no clearing pass is needed.
module ip_address_text_parser_unit #(
	parameter int QueueDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  character,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        addr_valid,
	output logic        mapped_v4,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low
);

	logic              push;
	logic              push_ready;
	iptp_pkg::token_t  push_tok;
	logic              pop_valid;
	logic              pop;
	logic              tok_ready;
	iptp_pkg::token_t  pop_tok;
	logic              snap_valid;
	logic              snap_ready;
	iptp_pkg::snap_t   snap;

	// advance the queue only when it holds a request
	assign pop = pop_valid && tok_ready;

	iptp_front u_front (
		.text_valid (text_valid),
		.text_ready (text_ready),
		.character  (character),
		.last       (last),
		.push       (push),
		.push_tok   (push_tok),
		.push_ready (push_ready)
	);

	iptp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_tok   (push_tok),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_tok    (pop_tok),
		.pop        (pop)
	);

	iptp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (pop_valid),
		.tok        (pop_tok),
		.tok_ready  (tok_ready),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready)
	);

	iptp_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.snap_valid   (snap_valid),
		.snap         (snap),
		.snap_ready   (snap_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.addr_valid   (addr_valid),
		.mapped_v4    (mapped_v4),
		.addr_high    (addr_high),
		.addr_low     (addr_low)
	);

endmodule
